@@ rtl/core/irc_line_parser_core_macros.svh @@
// Assertion macros for the IRC line parser core.
`ifndef IRC_LINE_PARSER_CORE_MACROS_SVH
`define IRC_LINE_PARSER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define ILP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ILP_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  `ILP_ASSERT(lbl, clk, rst_n, !(prop), msg)
`else
`define ILP_ASSERT(lbl, clk, rst_n, prop, msg)
`define ILP_ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

@@ rtl/core/ilp_pkg.sv @@
// Types, codes and keyword tables of the IRC line parser.
package ilp_pkg;

  localparam int MAX_PARAMS = 15;
  localparam int TDATA_W    = 32;
  localparam int TUSER_W    = 2;

  typedef enum logic [1:0] {
    KIND_PREFIX,
    KIND_MIDDLE,
    KIND_TRAIL,
    KIND_SUMMARY
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_CMD,
    ST_ILLEGAL,
    ST_PING_MANY,
    ST_PING_FEW,
    ST_OVERFLOW
  } status_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PONG,
    ACT_JOIN_QUEUE,
    ACT_QUEUE,
    ACT_LOG
  } action_e;

  localparam logic [4:0] CMD_UNKNOWN   = 5'd0;
  localparam logic [4:0] CMD_KW_PING   = 5'd1;
  localparam logic [4:0] CMD_END_MOTD  = 5'd16;
  localparam logic [6:0] KW_ALL        = 7'h7F;
  localparam int         KW_COUNT      = 7;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_COLON = 8'd58;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'd48 && b <= 8'd57;
  endfunction

  function automatic logic [3:0] kw_len(input logic [2:0] k);
    logic [3:0] n;
    case (k)
      3'd0:    n = 4'd4;
      3'd1:    n = 4'd6;
      3'd2:    n = 4'd7;
      3'd3:    n = 4'd5;
      3'd4:    n = 4'd4;
      3'd5:    n = 4'd5;
      3'd6:    n = 4'd5;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  // padding is never compared: positions past the length drop the keyword
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
    logic [63:0] s;
    case (k)
      3'd0:    s = "PING    ";
      3'd1:    s = "NOTICE  ";
      3'd2:    s = "PRIVMSG ";
      3'd3:    s = "SQUIT   ";
      3'd4:    s = "MODE    ";
      3'd5:    s = "TOPIC   ";
      3'd6:    s = "NAMES   ";
      default: s = '0;
    endcase
    return s[{3'd7 - pos, 3'b000} +: 8];
  endfunction

  function automatic logic [4:0] word_match(input logic [6:0] cand, input logic [3:0] pos);
    logic [4:0] cmd;
    cmd = CMD_UNKNOWN;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (cand[k] && kw_len(3'(k)) == pos) begin
        cmd = 5'(k + 1);
      end
    end
    return cmd;
  endfunction

  function automatic logic [4:0] num_code(input logic [9:0] v);
    logic [4:0] cmd;
    case (v)
      10'd221: cmd = 5'd8;
      10'd324: cmd = 5'd9;
      10'd331: cmd = 5'd10;
      10'd332: cmd = 5'd11;
      10'd353: cmd = 5'd12;
      10'd366: cmd = 5'd13;
      10'd372: cmd = 5'd14;
      10'd375: cmd = 5'd15;
      10'd376: cmd = 5'd16;
      default: cmd = CMD_UNKNOWN;
    endcase
    return cmd;
  endfunction

endpackage

@@ rtl/core/irc_line_parser_core.sv @@
// IRC line parser: byte-serial parse of prefix, command and parameters.
// One line byte is taken per request and one byte per clock is sustained: a byte goes
// from the input register through the single-pass parse logic into the result
// register. Input is held back only while the result register holds an item not yet
// taken. Prefix and parameter bytes come out as they arrive; CR or LF closes the line
// with a summary item, and lines of at most one content byte give nothing.
`include "irc_line_parser_core_macros.svh"

module irc_line_parser_core #(
  parameter int MaxParams = ilp_pkg::MAX_PARAMS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [7:0]                  s_axis_tdata_i,   // [7:0] data_byte
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [7:0] out_byte, [11:8] param_index, [16:12] command_code,
  // [20:17] param_count, [23:21] status, [26:24] action, rest zero
  output logic [ilp_pkg::TDATA_W-1:0] m_axis_tdata_o,
  output logic [ilp_pkg::TUSER_W-1:0] m_axis_tuser_o    // [1:0] item_kind
);
  import ilp_pkg::*;

  localparam int CntW = $clog2(MaxParams + 1);
  localparam int SatW = (CntW > 4) ? CntW : 4;

  typedef enum logic [3:0] {
    PH_START,
    PH_PREFIX,
    PH_AFTER_PREFIX,
    PH_WORD,
    PH_NUM,
    PH_GAP,
    PH_MIDDLE,
    PH_TRAIL,
    PH_ERROR
  } phase_e;

  logic            in_vld_q;
  logic [7:0]      in_byte_q;
  logic            adv;
  logic            proc;

  phase_e          ph_q, ph_d;
  logic [6:0]      cand_q, cand_d;
  logic [3:0]      pos_q, pos_d;
  logic [9:0]      num_q, num_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      bc_q, bc_d;
  status_e         err_q, err_d;
  logic [4:0]      cmd_q, cmd_d;

  logic            emit;
  kind_e           o_kind;
  logic [7:0]      o_byte;
  logic [3:0]      o_idx;
  logic [4:0]      o_cmd;
  logic [3:0]      o_cnt;
  status_e         o_st;
  action_e         o_act;

  logic            out_vld_q;
  kind_e           out_kind_q;
  logic [26:0]     out_data_q;

  logic [SatW-1:0] idx_ext;
  logic [SatW-1:0] cnt_ext;
  logic [3:0]      idx_sat;
  logic [3:0]      cnt_sat;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign proc            = in_vld_q && adv;
  assign s_axis_tready_o = !in_vld_q || adv;

  assign idx_ext = SatW'(cnt_q - 1'b1);
  assign cnt_ext = SatW'(cnt_q);
  assign idx_sat = (idx_ext > SatW'(15)) ? 4'd15 : idx_ext[3:0];
  assign cnt_sat = (cnt_ext > SatW'(15)) ? 4'd15 : cnt_ext[3:0];

  always_comb begin
    logic [7:0] b;
    logic       fin_err;
    b       = in_byte_q;
    fin_err = 1'b0;
    ph_d    = ph_q;
    cand_d  = cand_q;
    pos_d   = pos_q;
    num_d   = num_q;
    cnt_d   = cnt_q;
    bc_d    = bc_q;
    err_d   = err_q;
    cmd_d   = cmd_q;
    emit    = 1'b0;
    o_kind  = KIND_PREFIX;
    o_byte  = b;
    o_idx   = 4'd0;
    o_cmd   = CMD_UNKNOWN;
    o_cnt   = 4'd0;
    o_st    = ST_OK;
    o_act   = ACT_NONE;

    if (b == CHAR_CR || b == CHAR_LF) begin
      if (bc_q > 2'd1) begin
        emit   = 1'b1;
        o_kind = KIND_SUMMARY;
        o_byte = 8'd0;
        o_cnt  = cnt_sat;
        o_cmd  = cmd_q;
        case (ph_q)
          PH_WORD: o_cmd = word_match(cand_q, pos_q);
          PH_START, PH_PREFIX, PH_AFTER_PREFIX, PH_NUM: fin_err = 1'b1;
          default: ;
        endcase
        if (fin_err) begin
          o_st = ST_BAD_CMD;
        end else if (ph_q == PH_ERROR) begin
          o_st = err_q;
        end else if (o_cmd == CMD_KW_PING) begin
          if (cnt_q > CntW'(1)) begin
            o_st = ST_PING_MANY;
          end else if (cnt_q == '0) begin
            o_st = ST_PING_FEW;
          end else begin
            o_act = ACT_PONG;
          end
        end else if (o_cmd == CMD_UNKNOWN) begin
          o_act = ACT_LOG;
        end else if (o_cmd == CMD_END_MOTD) begin
          o_act = ACT_JOIN_QUEUE;
        end else begin
          o_act = ACT_QUEUE;
        end
      end
      ph_d   = PH_START;
      cand_d = KW_ALL;
      pos_d  = 4'd0;
      num_d  = 10'd0;
      cnt_d  = '0;
      bc_d   = 2'd0;
      err_d  = ST_OK;
      cmd_d  = CMD_UNKNOWN;
    end else begin
      if (bc_q < 2'd2) begin
        bc_d = bc_q + 2'd1;
      end
      case (ph_q)
        PH_START, PH_AFTER_PREFIX: begin
          if (ph_q == PH_START && b == CHAR_COLON) begin
            ph_d = PH_PREFIX;
          end else if (ph_q == PH_AFTER_PREFIX && b == CHAR_SPACE) begin
            ph_d = ph_q;
          end else if (is_letter(b)) begin
            ph_d  = PH_WORD;
            pos_d = 4'd1;
            for (int k = 0; k < KW_COUNT; k++) begin
              cand_d[k] = (kw_char(3'(k), 3'd0) == b);
            end
          end else if (is_digit(b)) begin
            ph_d  = PH_NUM;
            pos_d = 4'd1;
            num_d = 10'(b - 8'd48);
          end else begin
            ph_d  = PH_ERROR;
            err_d = ST_BAD_CMD;
          end
        end
        PH_PREFIX: begin
          if (b == CHAR_SPACE) begin
            ph_d = PH_AFTER_PREFIX;
          end else begin
            emit = 1'b1;
          end
        end
        PH_WORD: begin
          if (b == CHAR_SPACE) begin
            cmd_d = word_match(cand_q, pos_q);
            ph_d  = PH_GAP;
          end else if (is_letter(b)) begin
            for (int k = 0; k < KW_COUNT; k++) begin
              if (pos_q >= kw_len(3'(k)) || kw_char(3'(k), pos_q[2:0]) != b) begin
                cand_d[k] = 1'b0;
              end
            end
            if (pos_q < 4'd8) begin
              pos_d = pos_q + 4'd1;
            end
          end else begin
            ph_d  = PH_ERROR;
            err_d = ST_ILLEGAL;
          end
        end
        PH_NUM: begin
          if (pos_q < 4'd3) begin
            if (is_digit(b)) begin
              num_d = {num_q[6:0], 3'b000} + {num_q[8:0], 1'b0} + 10'(b - 8'd48);
              pos_d = pos_q + 4'd1;
            end else begin
              ph_d  = PH_ERROR;
              err_d = ST_BAD_CMD;
            end
          end else if (b == CHAR_SPACE) begin
            cmd_d = num_code(num_q);
            ph_d  = PH_GAP;
          end else begin
            ph_d  = PH_ERROR;
            err_d = ST_BAD_CMD;
          end
        end
        PH_GAP: begin
          if (b != CHAR_SPACE) begin
            if (cnt_q >= CntW'(MaxParams)) begin
              ph_d  = PH_ERROR;
              err_d = ST_OVERFLOW;
            end else begin
              cnt_d = cnt_q + 1'b1;
              if (b == CHAR_COLON) begin
                ph_d = PH_TRAIL;
              end else begin
                ph_d   = PH_MIDDLE;
                emit   = 1'b1;
                o_kind = KIND_MIDDLE;
                o_idx  = (cnt_ext > SatW'(15)) ? 4'd15 : cnt_ext[3:0];
              end
            end
          end
        end
        PH_MIDDLE: begin
          if (b == CHAR_SPACE) begin
            ph_d = PH_GAP;
          end else begin
            emit   = 1'b1;
            o_kind = KIND_MIDDLE;
            o_idx  = idx_sat;
          end
        end
        PH_TRAIL: begin
          emit   = 1'b1;
          o_kind = KIND_TRAIL;
          o_idx  = idx_sat;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      ph_q      <= PH_START;
      cand_q    <= KW_ALL;
      pos_q     <= 4'd0;
      num_q     <= 10'd0;
      cnt_q     <= '0;
      bc_q      <= 2'd0;
      err_q     <= ST_OK;
      cmd_q     <= CMD_UNKNOWN;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (adv) begin
        out_vld_q <= proc && emit;
      end
      if (proc) begin
        ph_q   <= ph_d;
        cand_q <= cand_d;
        pos_q  <= pos_d;
        num_q  <= num_d;
        cnt_q  <= cnt_d;
        bc_q   <= bc_d;
        err_q  <= err_d;
        cmd_q  <= cmd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (proc && emit) begin
      out_kind_q <= o_kind;
      out_data_q <= {o_act, o_st, o_cnt, o_cmd, o_idx, o_byte};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(TDATA_W - 27)'(0), out_data_q};
  assign m_axis_tuser_o  = out_kind_q;

  `ILP_ASSERT(a_hold_in, clk_i, rst_ni,
              in_vld_q && !adv |=> in_vld_q && $stable(in_byte_q), "input stage lost a byte")
  `ILP_ASSERT(a_start_clean, clk_i, rst_ni,
              ph_q == PH_START |-> bc_q == 2'd0 && cnt_q == '0, "line start with stale state")
  `ILP_ASSERT(a_err_code, clk_i, rst_ni,
              ph_q == PH_ERROR |-> err_q != ST_OK, "error phase without a code")
  `ILP_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni,
                    cnt_q > CntW'(MaxParams), "parameter count past limit")
  `ILP_ASSERT(a_byte_item, clk_i, rst_ni,
              out_vld_q && out_kind_q != KIND_SUMMARY |-> out_data_q[26:12] == 15'd0,
              "byte item carries summary fields")

endmodule
